FILE: sv/msw_pkg.sv
package msw_pkg;

  localparam int unsigned RING_DEPTH_DEF  = 1024;
  localparam int unsigned LEVEL_COUNT_DEF = 3;

  localparam int unsigned CFG_ADDR_W = 3;
  localparam logic [0:0]  REG_WINDOW = 1'b0;
  localparam logic [31:0] WINDOW_RESET = 32'd3600;

  localparam logic [31:0] MAX32 = '1;
  localparam logic [47:0] MAX48 = '1;

  typedef enum logic [1:0] {
    MODE_ADD    = 2'd0,
    MODE_EXPIRE = 2'd1,
    MODE_CLEAR  = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_EXP_RD,
    S_EXP_CMP,
    S_DONE
  } state_t;

endpackage

FILE: sv/msw_if.sv
interface msw_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [1:0]  level;
  logic [15:0] msg_length;
  logic [31:0] time_stamp;

  modport source (output valid, mode, level, msg_length, time_stamp, input ready);
  modport sink   (input valid, mode, level, msg_length, time_stamp, output ready);
endinterface

interface msw_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] total_count;
  logic [31:0] level_count;
  logic [47:0] length_sum;
  logic [15:0] min_length;
  logic [15:0] max_length;
  logic [10:0] window_count;
  logic        seen_any;
  logic        changed;
  logic        expired_some;
  logic        window_overflow;

  modport source (output valid, total_count, level_count, length_sum, min_length, max_length,
                  window_count, seen_any, changed, expired_some, window_overflow,
                  input ready);
  modport sink   (input valid, total_count, level_count, length_sum, min_length, max_length,
                  window_count, seen_any, changed, expired_some, window_overflow,
                  output ready);
endinterface

FILE: sv/message_stats_window_counter.sv
// Message statistics with a sliding window of recent time stamps. One transaction in gives
// one transaction out carrying every statistic; software divides length_sum by total_count
// for the mean. With the result register free, an add, a clear or an unused mode goes
// through the execute and done states into the result register. An expire walks the
// time-stamp ring from its head, one entry at a time (registered RAM read, then one shared
// 33-bit add-and-compare), and ends when the ring runs empty or a kept entry is found.
// The input is not ready while an item is in work; a finished result waits in the output
// register without holding up the next item's work until its final cycle. The user must
// write the window register over the APB port only while the block is idle; the block
// itself does not enforce this. No clearing pass is needed after reset.
module message_stats_window_counter
  import msw_pkg::*;
#(
  parameter int unsigned RING_DEPTH  = RING_DEPTH_DEF,
  parameter int unsigned LEVEL_COUNT = LEVEL_COUNT_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  msw_in_if.sink                in_chan,
  msw_out_if.source             out_chan,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  localparam int unsigned PTR_W  = $clog2(RING_DEPTH);
  localparam int unsigned FILL_W = $clog2(RING_DEPTH + 1);
  localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(RING_DEPTH - 1);
  localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(RING_DEPTH);
  localparam logic [PTR_W-1:0]  PTR_ONE  = PTR_W'(1);
  localparam logic [FILL_W-1:0] FILL_ONE = FILL_W'(1);

  state_t state_r, state_nxt;

  logic [31:0] window_r;

  mode_t       mode_r;
  logic [1:0]  level_r;
  logic [15:0] len_r;
  logic [31:0] ts_r;

  logic [31:0] total_r, total_nxt;
  logic [31:0] lvl_cnt_r [LEVEL_COUNT];
  logic [31:0] lvl_cnt_nxt [LEVEL_COUNT];
  logic [47:0] sum_r, sum_nxt;
  logic [15:0] min_r, min_nxt;
  logic [15:0] max_r, max_nxt;
  logic        seen_r, seen_nxt;
  logic        dirty_r, dirty_nxt;
  logic        expired_r, expired_nxt;
  logic        ovf_r, ovf_nxt;

  logic [PTR_W-1:0]  head_r, head_nxt;
  logic [PTR_W-1:0]  tail_r, tail_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;

  logic [31:0] ring_mem [RING_DEPTH];
  logic [31:0] rd_data_r;
  logic        wr_en;

  logic        out_valid_r, out_valid_nxt;
  logic        out_load;
  logic [31:0] o_total_r, o_level_r;
  logic [47:0] o_sum_r;
  logic [15:0] o_min_r, o_max_r;
  logic [10:0] o_wcount_r;
  logic        o_seen_r, o_changed_r, o_expired_r, o_ovf_r;

  logic [31:0]        lvl_sel;
  logic [48:0]        sum_add;
  logic [32:0]        age_limit;
  logic               is_old;
  logic [FILL_W+10:0] fill_ext;

  logic cfg_wr;

  // configuration
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;
  assign prdata = (paddr[CFG_ADDR_W-1:2] == REG_WINDOW) ? window_r : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= WINDOW_RESET;
    end else if (cfg_wr && paddr[CFG_ADDR_W-1:2] == REG_WINDOW) begin
      window_r <= pwdata;
    end
  end

  // shared compare unit: stamp + window < now, no wrap
  assign age_limit = {1'b0, rd_data_r} + {1'b0, window_r};
  assign is_old    = age_limit < {1'b0, ts_r};

  assign sum_add  = {1'b0, sum_r} + {33'd0, len_r};
  assign fill_ext = {11'd0, fill_r};

  always_comb begin
    lvl_sel = 32'd0;
    for (int i = 0; i < LEVEL_COUNT; i++) begin
      if (32'(level_r) == i) begin
        lvl_sel = lvl_cnt_r[i];
      end
    end
  end

  assign in_chan.ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt   = state_r;
    total_nxt   = total_r;
    lvl_cnt_nxt = lvl_cnt_r;
    sum_nxt     = sum_r;
    min_nxt     = min_r;
    max_nxt     = max_r;
    seen_nxt    = seen_r;
    dirty_nxt   = dirty_r;
    expired_nxt = expired_r;
    ovf_nxt     = ovf_r;
    head_nxt    = head_r;
    tail_nxt    = tail_r;
    fill_nxt    = fill_r;
    wr_en       = 1'b0;
    out_load    = 1'b0;
    out_valid_nxt = out_valid_r & ~out_chan.ready;

    case (state_r)
      S_IDLE: begin
        if (in_chan.valid) begin
          expired_nxt = 1'b0;
          ovf_nxt     = 1'b0;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        case (mode_r)
          MODE_ADD: begin
            if (total_r != MAX32) begin
              total_nxt = total_r + 32'd1;
            end
            for (int i = 0; i < LEVEL_COUNT; i++) begin
              if (32'(level_r) == i && lvl_cnt_r[i] != MAX32) begin
                lvl_cnt_nxt[i] = lvl_cnt_r[i] + 32'd1;
              end
            end
            sum_nxt = sum_add[48] ? MAX48 : sum_add[47:0];
            if (fill_r >= FILL_MAX) begin
              ovf_nxt = 1'b1;
            end else begin
              wr_en    = 1'b1;
              tail_nxt = (tail_r == PTR_LAST) ? '0 : tail_r + PTR_ONE;
              fill_nxt = fill_r + FILL_ONE;
            end
            if (!seen_r) begin
              min_nxt  = len_r;
              max_nxt  = len_r;
              seen_nxt = 1'b1;
            end else begin
              if (len_r < min_r) min_nxt = len_r;
              if (len_r > max_r) max_nxt = len_r;
            end
            dirty_nxt = 1'b1;
            state_nxt = S_DONE;
          end
          MODE_EXPIRE: begin
            state_nxt = S_EXP_RD;
          end
          MODE_CLEAR: begin
            dirty_nxt = 1'b0;
            state_nxt = S_DONE;
          end
          default: begin
            state_nxt = S_DONE;
          end
        endcase
      end
      S_EXP_RD: begin
        // ring read of the head entry lands in rd_data_r
        state_nxt = (fill_r == '0) ? S_DONE : S_EXP_CMP;
      end
      S_EXP_CMP: begin
        if (is_old) begin
          head_nxt    = (head_r == PTR_LAST) ? '0 : head_r + PTR_ONE;
          fill_nxt    = fill_r - FILL_ONE;
          expired_nxt = 1'b1;
          dirty_nxt   = 1'b1;
          state_nxt   = S_EXP_RD;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_chan.ready) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      total_r     <= '0;
      sum_r       <= '0;
      min_r       <= '0;
      max_r       <= '0;
      seen_r      <= 1'b0;
      dirty_r     <= 1'b0;
      expired_r   <= 1'b0;
      ovf_r       <= 1'b0;
      head_r      <= '0;
      tail_r      <= '0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < LEVEL_COUNT; i++) begin
        lvl_cnt_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      total_r     <= total_nxt;
      lvl_cnt_r   <= lvl_cnt_nxt;
      sum_r       <= sum_nxt;
      min_r       <= min_nxt;
      max_r       <= max_nxt;
      seen_r      <= seen_nxt;
      dirty_r     <= dirty_nxt;
      expired_r   <= expired_nxt;
      ovf_r       <= ovf_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // accepted transaction
  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      mode_r  <= mode_t'(in_chan.mode);
      level_r <= in_chan.level;
      len_r   <= in_chan.msg_length;
      ts_r    <= in_chan.time_stamp;
    end
  end

  // time-stamp ring
  always_ff @(posedge clk) begin
    if (wr_en) begin
      ring_mem[tail_r] <= ts_r;
    end
    rd_data_r <= ring_mem[head_r];
  end

  // result register
  always_ff @(posedge clk) begin
    if (out_load) begin
      o_total_r   <= total_r;
      o_level_r   <= lvl_sel;
      o_sum_r     <= sum_r;
      o_min_r     <= min_r;
      o_max_r     <= max_r;
      o_wcount_r  <= fill_ext[10:0];
      o_seen_r    <= seen_r;
      o_changed_r <= dirty_r;
      o_expired_r <= expired_r;
      o_ovf_r     <= ovf_r;
    end
  end

  assign out_chan.valid           = out_valid_r;
  assign out_chan.total_count     = o_total_r;
  assign out_chan.level_count     = o_level_r;
  assign out_chan.length_sum      = o_sum_r;
  assign out_chan.min_length      = o_min_r;
  assign out_chan.max_length      = o_max_r;
  assign out_chan.window_count    = o_wcount_r;
  assign out_chan.seen_any        = o_seen_r;
  assign out_chan.changed         = o_changed_r;
  assign out_chan.expired_some    = o_expired_r;
  assign out_chan.window_overflow = o_ovf_r;

endmodule

FILE: sim/testbench.sv
module testbench
  import msw_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [1:0]  mode;
    logic [1:0]  level;
    logic [15:0] msg_length;
    logic [31:0] time_stamp;
  } log_msg_t;

  typedef struct packed {
    logic [31:0] total_count;
    logic [31:0] level_count;
    logic [47:0] length_sum;
    logic [15:0] min_length;
    logic [15:0] max_length;
    logic [10:0] window_count;
    logic        seen_any;
    logic        changed;
    logic        expired_some;
    logic        window_overflow;
  } msg_stats_t;

  // Tracks the statistics and stamp ring, queues the stats each message should produce.
  class msg_stats_book;
    logic [31:0] window_secs;
    logic [31:0] total;
    logic [31:0] per_level [LEVEL_COUNT_DEF];
    logic [47:0] len_sum;
    logic [15:0] shortest;
    logic [15:0] longest;
    bit          seen;
    bit          dirty;
    logic [31:0] stamps [RING_DEPTH_DEF];
    int unsigned head;
    int unsigned tail;
    int unsigned fill;
    int unsigned overflows;
    int unsigned mismatches;
    int unsigned results;
    msg_stats_t  awaited [$];

    function new();
      window_secs = WINDOW_RESET;
      total = '0;
      foreach (per_level[i]) per_level[i] = '0;
      len_sum = '0;
      shortest = '0;
      longest = '0;
      seen = 1'b0;
      dirty = 1'b0;
      head = 0;
      tail = 0;
      fill = 0;
      overflows = 0;
      mismatches = 0;
      results = 0;
    endfunction

    function void set_window(logic [31:0] w);
      window_secs = w;
    endfunction

    function logic [31:0] sat_inc(logic [31:0] v);
      return (v == MAX32) ? v : v + 32'd1;
    endfunction

    function void note_msg(log_msg_t m);
      msg_stats_t r;
      logic [48:0] wide_sum;
      r = '0;
      if (m.mode == MODE_ADD) begin
        total = sat_inc(total);
        if (m.level < LEVEL_COUNT_DEF) per_level[m.level] = sat_inc(per_level[m.level]);
        wide_sum = {1'b0, len_sum} + m.msg_length;
        len_sum = wide_sum[48] ? MAX48 : wide_sum[47:0];
        if (fill >= RING_DEPTH_DEF) begin
          r.window_overflow = 1'b1;
          overflows++;
        end else begin
          stamps[tail] = m.time_stamp;
          tail = (tail + 1) % RING_DEPTH_DEF;
          fill++;
        end
        if (!seen) begin
          shortest = m.msg_length;
          longest = m.msg_length;
          seen = 1'b1;
        end else begin
          if (m.msg_length < shortest) shortest = m.msg_length;
          if (m.msg_length > longest) longest = m.msg_length;
        end
        dirty = 1'b1;
      end else if (m.mode == MODE_EXPIRE) begin
        // 33-bit sum: no wrap, so nothing ages out while now < window
        while (fill > 0 && ({1'b0, stamps[head]} + {1'b0, window_secs}) < {1'b0, m.time_stamp})
        begin
          head = (head + 1) % RING_DEPTH_DEF;
          fill--;
          r.expired_some = 1'b1;
        end
        if (r.expired_some) dirty = 1'b1;
      end else if (m.mode == MODE_CLEAR) begin
        dirty = 1'b0;
      end
      r.total_count = total;
      if (m.level < LEVEL_COUNT_DEF) r.level_count = per_level[m.level];
      r.length_sum = len_sum;
      r.min_length = shortest;
      r.max_length = longest;
      r.window_count = 11'(fill);
      r.seen_any = seen;
      r.changed = dirty;
      awaited.insert(awaited.size(), r);
    endfunction

    task report(string msg);
      if (mismatches < 100) $display("%0t ns  mismatch: %s", $realtime, msg);
      mismatches++;
    endtask

    task cmp(string name, logic [63:0] got, logic [63:0] want);
      if (got !== want)
        report($sformatf("result %0d %s got %0h want %0h", results, name, got, want));
    endtask

    task check_stats(msg_stats_t got);
      msg_stats_t want;
      if (awaited.size() == 0) begin
        report($sformatf("result %0d arrived with nothing awaited", results));
      end else begin
        want = awaited[0];
        awaited.delete(0);
        cmp("total_count", got.total_count, want.total_count);
        cmp("level_count", got.level_count, want.level_count);
        cmp("length_sum", got.length_sum, want.length_sum);
        cmp("min_length", got.min_length, want.min_length);
        cmp("max_length", got.max_length, want.max_length);
        cmp("window_count", got.window_count, want.window_count);
        cmp("seen_any", got.seen_any, want.seen_any);
        cmp("changed", got.changed, want.changed);
        cmp("expired_some", got.expired_some, want.expired_some);
        cmp("window_overflow", got.window_overflow, want.window_overflow);
      end
      results++;
    endtask
  endclass

  localparam int unsigned STALL_LIMIT   = 20000;
  localparam int unsigned SETTLE_CYCLES = 12;
  localparam logic [31:0] STAMP_MAX     = '1;
  localparam logic [1:0]  MODE_UNUSED   = 2'd3;
  localparam logic [1:0]  LVL_DEBUG     = 2'd0;
  localparam logic [1:0]  LVL_INFO      = 2'd1;
  localparam logic [1:0]  LVL_ERROR     = 2'd2;
  localparam logic [1:0]  LVL_UNUSED    = 2'd3;
  localparam logic [CFG_ADDR_W-1:0] WINDOW_ADDR = {REG_WINDOW, 2'b00};

  logic                  clk;
  logic                  rst_n;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [31:0]           pwdata;
  logic [31:0]           prdata;
  logic                  pready;

  msw_in_if  in_chan ();
  msw_out_if out_chan ();

  message_stats_window_counter dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  msg_stats_book book;
  int unsigned   burst_left;
  bit            sender_eager;
  int unsigned   stall_style;
  int unsigned   stall_run;
  int unsigned   quiet;
  logic [31:0]   sim_now;

  always begin
    clk = 1'b1;
    #1ns;
    clk = 1'b0;
    #1ns;
  end

  function automatic log_msg_t mk(logic [1:0] mode, logic [1:0] level, logic [15:0] len,
                                  logic [31:0] stamp);
    log_msg_t m;
    m.mode = mode;
    m.level = level;
    m.msg_length = len;
    m.time_stamp = stamp;
    return m;
  endfunction

  function automatic logic [15:0] pick_len();
    case ($urandom_range(0, 9))
      0: return 16'd0;
      1: return 16'hFFFF;
      2, 3, 4: return 16'($urandom_range(0, 255));
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic log_msg_t noise_msg();
    return mk(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)), pick_len(), $urandom());
  endfunction

  task automatic send_msg(log_msg_t m);
    int unsigned gap;
    in_chan.valid <= 1'b1;
    in_chan.mode <= m.mode;
    in_chan.level <= m.level;
    in_chan.msg_length <= m.msg_length;
    in_chan.time_stamp <= m.time_stamp;
    do @(posedge clk); while (!in_chan.ready);
    book.note_msg(m);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      if (sender_eager) gap = 0;
      else if ($urandom_range(0, 9) == 0) gap = $urandom_range(10, 30);
      else gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_chan.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic drain();
    in_chan.valid <= 1'b0;
    while (book.awaited.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // write the window register, then read it back
  task automatic set_window(logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= WINDOW_ADDR;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    book.set_window(value);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== value)
      book.report($sformatf("window readback got %0h want %0h", prdata, value));
    psel <= 1'b0;
    penable <= 1'b0;
    sender_eager = ($urandom_range(0, 3) == 0);
  endtask

  // mostly ascending stamps with expiries at the current time
  task automatic run_timeline(int unsigned n, int unsigned max_step);
    int unsigned roll;
    for (int unsigned i = 0; i < n; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < 8) send_msg(noise_msg());
      else if (roll < 60)
        send_msg(mk(MODE_ADD, 2'($urandom_range(0, 2)), pick_len(),
                    sim_now - $urandom_range(0, 2)));
      else if (roll < 85) send_msg(mk(MODE_EXPIRE, 2'($urandom_range(0, 3)), pick_len(), sim_now));
      else if (roll < 93) send_msg(mk(MODE_CLEAR, 2'($urandom_range(0, 3)), pick_len(), $urandom()));
      else send_msg(mk(MODE_UNUSED, 2'($urandom_range(0, 3)), pick_len(), $urandom()));
      sim_now = sim_now + $urandom_range(0, max_step);
    end
  endtask

  always @(posedge clk) begin
    msg_stats_t got;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      got.total_count = out_chan.total_count;
      got.level_count = out_chan.level_count;
      got.length_sum = out_chan.length_sum;
      got.min_length = out_chan.min_length;
      got.max_length = out_chan.max_length;
      got.window_count = out_chan.window_count;
      got.seen_any = out_chan.seen_any;
      got.changed = out_chan.changed;
      got.expired_some = out_chan.expired_some;
      got.window_overflow = out_chan.window_overflow;
      book.check_stats(got);
    end
    if (stall_run == 0) begin
      stall_style = $urandom_range(0, 2);
      stall_run = $urandom_range(32, 256);
    end else begin
      stall_run--;
    end
    case (stall_style)
      0: out_chan.ready <= 1'b1;
      1: out_chan.ready <= 1'($urandom_range(0, 1));
      default: out_chan.ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  always @(posedge clk) begin
    if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready) ||
        (psel && penable)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= STALL_LIMIT) begin
        $display("** message_stats_window_counter: FAILED **");
        $finish;
      end
    end
  end

  initial begin
    int unsigned overflow_goal;
    int unsigned roll;
    book = new();
    burst_left = 1;
    sender_eager = 1'b0;
    sim_now = '0;
    rst_n <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    in_chan.valid <= 1'b0;
    in_chan.mode <= MODE_ADD;
    in_chan.level <= LVL_DEBUG;
    in_chan.msg_length <= '0;
    in_chan.time_stamp <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset value of the window
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= WINDOW_ADDR;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== WINDOW_RESET)
      book.report($sformatf("window after reset got %0h", prdata));
    psel <= 1'b0;
    penable <= 1'b0;

    send_msg(mk(MODE_CLEAR, LVL_DEBUG, 16'd0, 32'd0));
    send_msg(mk(MODE_EXPIRE, LVL_INFO, 16'd0, STAMP_MAX));
    send_msg(mk(MODE_UNUSED, LVL_UNUSED, 16'hFFFF, STAMP_MAX));
    send_msg(mk(MODE_ADD, LVL_DEBUG, 16'd100, 32'd0));
    send_msg(mk(MODE_ADD, LVL_INFO, 16'd0, 32'd10));
    send_msg(mk(MODE_ADD, LVL_ERROR, 16'hFFFF, 32'd3000));
    send_msg(mk(MODE_ADD, LVL_UNUSED, 16'd5, 32'd4000));
    send_msg(mk(MODE_ADD, LVL_INFO, 16'd200, 32'd5));
    send_msg(mk(MODE_EXPIRE, LVL_DEBUG, 16'd0, 32'd3599));
    send_msg(mk(MODE_EXPIRE, LVL_ERROR, 16'd0, 32'd3601));
    send_msg(mk(MODE_CLEAR, LVL_INFO, 16'd0, 32'd0));
    send_msg(mk(MODE_EXPIRE, LVL_INFO, 16'd0, 32'd3601));
    send_msg(mk(MODE_UNUSED, LVL_ERROR, 16'd0, 32'd0));
    send_msg(mk(MODE_EXPIRE, LVL_UNUSED, 16'd0, 32'd7605));
    // a late stamp at the head holds back an older one behind it
    send_msg(mk(MODE_ADD, LVL_ERROR, 16'd1, 32'hFFFF_FFF0));
    send_msg(mk(MODE_ADD, LVL_DEBUG, 16'hFFFF, 32'd1));
    send_msg(mk(MODE_EXPIRE, LVL_DEBUG, 16'd0, 32'h0001_0000));
    send_msg(mk(MODE_EXPIRE, LVL_INFO, 16'd0, STAMP_MAX));
    drain();
    set_window(32'd1);
    send_msg(mk(MODE_EXPIRE, LVL_ERROR, 16'd0, STAMP_MAX));
    send_msg(mk(MODE_ADD, LVL_DEBUG, 16'd7, 32'd5));
    send_msg(mk(MODE_EXPIRE, LVL_DEBUG, 16'd0, 32'd6));
    send_msg(mk(MODE_EXPIRE, LVL_DEBUG, 16'd0, 32'd7));
    drain();
    set_window(STAMP_MAX);
    send_msg(mk(MODE_ADD, LVL_INFO, 16'd3, 32'd0));
    send_msg(mk(MODE_EXPIRE, LVL_INFO, 16'd0, STAMP_MAX));
    drain();

    set_window($urandom_range(1, 16));
    sim_now = $urandom();
    run_timeline(24, 4);
    drain();

    // nothing ages out: fill the ring and run past full
    set_window(STAMP_MAX);
    overflow_goal = book.overflows + 8;
    while (book.overflows < overflow_goal) begin
      roll = $urandom_range(0, 99);
      if (roll < 97) send_msg(mk(MODE_ADD, 2'($urandom_range(0, 2)), pick_len(), $urandom()));
      else if (roll < 99) send_msg(mk(MODE_CLEAR, 2'($urandom_range(0, 3)), pick_len(), $urandom()));
      else send_msg(noise_msg());
    end
    drain();

    set_window(32'd1);
    send_msg(mk(MODE_EXPIRE, LVL_INFO, 16'd0, STAMP_MAX));
    sim_now = $urandom();
    run_timeline(24, 3);
    drain();

    set_window($urandom());
    sim_now = $urandom();
    for (int unsigned i = 0; i < 8; i++) send_msg(noise_msg());
    run_timeline(8, 32'h1000_0000);
    drain();

    set_window(WINDOW_RESET);
    sim_now = $urandom();
    run_timeline(16, 2000);
    drain();

    if (book.mismatches == 0) begin
      $display("** message_stats_window_counter: PASSED **");
    end else begin
      $display("** message_stats_window_counter: FAILED **");
    end
    $finish;
  end
endmodule

FILE: message_stats_window_counter.f
sv/msw_pkg.sv
sv/msw_if.sv
sv/message_stats_window_counter.sv
sim/testbench.sv
